/* hw/rtl/rlf_pkg.sv */
// ----------------------------------------------------------------------------
// rlf_pkg
// Shared constants, types and helpers of the largest-first coloring core.
// ----------------------------------------------------------------------------
package rlf_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned VidW        = 6;   // vertex index width
  localparam int unsigned CntW        = 7;   // counts up to MaxVertices
  localparam int unsigned NumLanes    = 2;
  localparam int unsigned PairW       = 5;   // index of a lane pair

  typedef logic [MaxVertices-1:0] row_t;

  // what one lane finds for the vertex it examines
  typedef struct packed {
    logic            valid;   // vertex may join the class
    logic [CntW-1:0] key_a;   // shared neighbours, or initial degree when seeding
    logic [CntW-1:0] key_b;   // uncolored neighbours
  } lane_res_t;

  // best vertex found so far in one sweep
  typedef struct packed {
    logic            valid;
    logic [CntW-1:0] key;
    logic [VidW-1:0] idx;
    row_t            row;
  } best_t;

  // population count of one row
  function automatic logic [CntW-1:0] pop_row(row_t x);
    logic [CntW-1:0] c;
    c = '0;
    for (int b = 0; b < MaxVertices; b++) begin
      c = c + CntW'(x[b]);
    end
    return c;
  endfunction

endpackage

/* hw/rtl/rlf_adj_mem.sv */
// ----------------------------------------------------------------------------
// rlf_adj_mem
// Adjacency row store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rlf_adj_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [rlf_pkg::VidW-1:0]  waddr_i,
  input  rlf_pkg::row_t             wdata_i,
  input  logic [rlf_pkg::VidW-1:0]  raddr0_i,
  input  logic [rlf_pkg::VidW-1:0]  raddr1_i,
  output rlf_pkg::row_t             rdata0_o,
  output rlf_pkg::row_t             rdata1_o
);
  import rlf_pkg::*;

  row_t mem_q [MaxVertices];
  row_t rd0_q, rd1_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // two read ports, registered
  always_ff @(posedge clk_i) begin
    rd0_q <= mem_q[raddr0_i];
    rd1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rd0_q;
  assign rdata1_o = rd1_q;

endmodule

/* hw/rtl/rlf_lane.sv */
// ----------------------------------------------------------------------------
// rlf_lane
// Scores one vertex against the current class from its adjacency row.
// ----------------------------------------------------------------------------
module rlf_lane (
  input  rlf_pkg::row_t             row_i,
  input  logic [rlf_pkg::VidW-1:0]  idx_i,
  input  rlf_pkg::row_t             unc_i,
  input  rlf_pkg::row_t             cls_i,
  input  rlf_pkg::row_t             nbrs_i,
  input  rlf_pkg::row_t             vmask_i,
  input  logic                      seed_i,
  output rlf_pkg::lane_res_t        res_o
);
  import rlf_pkg::*;

  // eligibility: uncolored, and no neighbour in the class unless seeding
  assign res_o.valid = unc_i[idx_i] && (seed_i || ((row_i & cls_i) == '0));

  // primary key: initial degree for the seed, shared neighbours otherwise
  assign res_o.key_a = seed_i ? pop_row(row_i & vmask_i)
                              : pop_row(row_i & nbrs_i & unc_i);

  // fallback key: uncolored neighbours
  assign res_o.key_b = pop_row(row_i & unc_i);

endmodule

/* hw/rtl/rlf_merge.sv */
// ----------------------------------------------------------------------------
// rlf_merge
// Folds the lane results of one pair into the running best of the sweep.
// ----------------------------------------------------------------------------
module rlf_merge (
  input  rlf_pkg::best_t                   best_a_i,
  input  rlf_pkg::best_t                   best_b_i,
  input  rlf_pkg::lane_res_t               lane0_i,
  input  rlf_pkg::lane_res_t               lane1_i,
  input  logic [rlf_pkg::VidW-1:0]         idx0_i,
  input  logic [rlf_pkg::VidW-1:0]         idx1_i,
  input  rlf_pkg::row_t                    row0_i,
  input  rlf_pkg::row_t                    row1_i,
  output rlf_pkg::best_t                   best_a_o,
  output rlf_pkg::best_t                   best_b_o
);
  import rlf_pkg::*;

  // strictly greater wins, so the lower index keeps ties
  function automatic best_t fold(best_t b, logic v, logic [CntW-1:0] k,
                                 logic [VidW-1:0] i, row_t r);
    best_t n;
    n = b;
    if (v && (!b.valid || (k > b.key))) begin
      n.valid = 1'b1;
      n.key   = k;
      n.idx   = i;
      n.row   = r;
    end
    return n;
  endfunction

  // lower-index lane first
  assign best_a_o = fold(fold(best_a_i, lane0_i.valid, lane0_i.key_a, idx0_i, row0_i),
                         lane1_i.valid, lane1_i.key_a, idx1_i, row1_i);
  assign best_b_o = fold(fold(best_b_i, lane0_i.valid, lane0_i.key_b, idx0_i, row0_i),
                         lane1_i.valid, lane1_i.key_b, idx1_i, row1_i);

endmodule

/* hw/rtl/rlf_graph_coloring_core.sv */
// ----------------------------------------------------------------------------
// rlf_graph_coloring_core
// Recursive Largest First coloring with two scoring lanes and a merge stage.
// ----------------------------------------------------------------------------
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-------------------------------
//  command  | start in, busy out             | vertex_index, adjacency_row,
//           |                                | last_row
//  result   | result_valid_o, one cycle      | vertex_id, color_class,
//           |                                | last_result
//  config   | cfg_we_i                       | cfg_wdata_i (vertex_count)
//
// Each accepted start writes one row. After the last row, each selection sweep
// reads two rows per cycle from the two-port row store, one sweep per vertex
// picked plus one sweep per color class, then one result per vertex. Reset
// clears control state only; rows are kept.
// The receiver cannot stall; results go out one per cycle.
module rlf_graph_coloring_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [rlf_pkg::VidW-1:0]  vertex_index_i,
  input  rlf_pkg::row_t             adjacency_row_i,
  input  logic                      last_row_i,
  input  logic                      cfg_we_i,
  input  logic [rlf_pkg::CntW-1:0]  cfg_wdata_i,
  output logic                      result_valid_o,
  output logic [rlf_pkg::VidW-1:0]  vertex_id_o,
  output logic [rlf_pkg::VidW-1:0]  color_class_o,
  output logic                      last_result_o
);
  import rlf_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StInit,
    StSweep,
    StDrain,
    StDecide,
    StEmit
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cfg_n_q;
  logic [CntW-1:0] n_q;
  row_t            vmask_q, unc_q, cls_q, nbrs_q;
  logic            seed_q;
  logic [VidW-1:0] class_q;
  logic [PairW-1:0] pair_q, rd_pair_q;
  logic            rd_valid_q;
  logic [CntW-1:0] emit_q;
  best_t           best_a_q, best_b_q, best_a_d, best_b_d;
  logic            res_valid_q, res_last_q;
  logic [VidW-1:0] res_id_q, color_rd_q;
  logic [VidW-1:0] color_mem_q [MaxVertices];

  logic            accept;
  logic [CntW-1:0] n_clamp;
  row_t            row0, row1;
  logic [VidW-1:0] idx0, idx1;
  lane_res_t       lane0, lane1;
  best_t           pick;
  logic            last_pair;
  logic            color_we;

  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);

  // clamp the vertex count to 1..MaxVertices
  always_comb begin
    n_clamp = cfg_n_q;
    if (cfg_n_q == '0) begin
      n_clamp = CntW'(1);
    end else if (cfg_n_q > CntW'(MaxVertices)) begin
      n_clamp = CntW'(MaxVertices);
    end
  end

  // row store, pair of reads per sweep cycle
  rlf_adj_mem u_mem (
    .clk_i    (clk_i),
    .we_i     (accept),
    .waddr_i  (vertex_index_i),
    .wdata_i  (adjacency_row_i),
    .raddr0_i ({pair_q, 1'b0}),
    .raddr1_i ({pair_q, 1'b1}),
    .rdata0_o (row0),
    .rdata1_o (row1)
  );

  assign idx0 = {rd_pair_q, 1'b0};
  assign idx1 = {rd_pair_q, 1'b1};

  // scoring lanes
  rlf_lane u_lane0 (
    .row_i (row0), .idx_i (idx0), .unc_i (unc_q), .cls_i (cls_q),
    .nbrs_i (nbrs_q), .vmask_i (vmask_q), .seed_i (seed_q), .res_o (lane0)
  );
  rlf_lane u_lane1 (
    .row_i (row1), .idx_i (idx1), .unc_i (unc_q), .cls_i (cls_q),
    .nbrs_i (nbrs_q), .vmask_i (vmask_q), .seed_i (seed_q), .res_o (lane1)
  );

  // merge stage
  rlf_merge u_merge (
    .best_a_i (best_a_q), .best_b_i (best_b_q),
    .lane0_i (lane0), .lane1_i (lane1),
    .idx0_i (idx0), .idx1_i (idx1), .row0_i (row0), .row1_i (row1),
    .best_a_o (best_a_d), .best_b_o (best_b_d)
  );

  assign last_pair = ({1'b0, pair_q, 1'b0} + CntW'(2)) >= n_q;

  // seeds by degree; else shared neighbours if any, else most uncolored
  assign pick = (seed_q || (best_a_q.key != '0)) ? best_a_q : best_b_q;

  assign color_we = (state_q == StDecide) && best_a_q.valid;

  // color store
  always_ff @(posedge clk_i) begin
    if (color_we) begin
      color_mem_q[pick.idx] <= class_q;
    end
    color_rd_q <= color_mem_q[emit_q[VidW-1:0]];
  end

  // control, sweep state and registered result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cfg_n_q     <= CntW'(MaxVertices);
      n_q         <= CntW'(MaxVertices);
      vmask_q     <= '0;
      unc_q       <= '0;
      cls_q       <= '0;
      nbrs_q      <= '0;
      seed_q      <= 1'b1;
      class_q     <= '0;
      pair_q      <= '0;
      rd_pair_q   <= '0;
      rd_valid_q  <= 1'b0;
      emit_q      <= '0;
      best_a_q    <= '0;
      best_b_q    <= '0;
      res_valid_q <= 1'b0;
      res_last_q  <= 1'b0;
      res_id_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_n_q <= cfg_wdata_i;
      end
      res_valid_q <= (state_q == StEmit);
      rd_valid_q  <= (state_q == StSweep);
      rd_pair_q   <= pair_q;
      if (rd_valid_q) begin
        best_a_q <= best_a_d;
        best_b_q <= best_b_d;
      end
      unique case (state_q)
        StIdle: begin
          if (accept && last_row_i) begin
            n_q     <= n_clamp;
            state_q <= StInit;
          end
        end
        StInit: begin
          vmask_q  <= (n_q >= CntW'(MaxVertices)) ? '1
                      : ((row_t'(1) << n_q[VidW-1:0]) - row_t'(1));
          unc_q    <= (n_q >= CntW'(MaxVertices)) ? '1
                      : ((row_t'(1) << n_q[VidW-1:0]) - row_t'(1));
          cls_q    <= '0;
          nbrs_q   <= '0;
          seed_q   <= 1'b1;
          class_q  <= '0;
          pair_q   <= '0;
          best_a_q <= '0;
          best_b_q <= '0;
          state_q  <= StSweep;
        end
        StSweep: begin
          if (last_pair) begin
            state_q <= StDrain;
          end else begin
            pair_q <= pair_q + PairW'(1);
          end
        end
        StDrain: begin
          state_q <= StDecide;
        end
        StDecide: begin
          pair_q   <= '0;
          best_a_q <= '0;
          best_b_q <= '0;
          if (best_a_q.valid) begin
            cls_q   <= cls_q | (row_t'(1) << pick.idx);
            unc_q   <= unc_q & ~(row_t'(1) << pick.idx);
            nbrs_q  <= nbrs_q | pick.row;
            seed_q  <= 1'b0;
            state_q <= StSweep;
          end else begin
            // class closed
            class_q <= class_q + VidW'(1);
            cls_q   <= '0;
            nbrs_q  <= '0;
            seed_q  <= 1'b1;
            if (unc_q == '0) begin
              emit_q  <= '0;
              state_q <= StEmit;
            end else begin
              state_q <= StSweep;
            end
          end
        end
        StEmit: begin
          res_id_q    <= emit_q[VidW-1:0];
          res_last_q  <= (emit_q + CntW'(1)) == n_q;
          emit_q      <= emit_q + CntW'(1);
          if ((emit_q + CntW'(1)) == n_q) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign vertex_id_o    = res_id_q;
  assign color_class_o  = color_rd_q;
  assign last_result_o  = res_last_q;

  // a picked vertex is still uncolored
  a_pick_uncolored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    color_we |-> unc_q[pick.idx])
    else $error("picked vertex already colored");

  // a vertex joining a class has no neighbour in it
  a_pick_independent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (color_we && !seed_q) |-> ((pick.row & cls_q) == '0))
    else $error("class member adjacent to new vertex");

  // results only start once every vertex is colored
  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (unc_q == '0))
    else $error("result emitted with uncolored vertices");

  // the final result carries the last vertex
  a_last_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_result_o) |-> ({1'b0, vertex_id_o} + CntW'(1) == n_q))
    else $error("last result on wrong vertex");

endmodule
